// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the cache replacement checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define ACR_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define ACR_ASSERT_ANY(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/acr_pkg.sv =====
// ---------------------------------------------------------------------------
// acr_pkg
// Types, list codes and port widths shared by the ARC replacement block.
// ---------------------------------------------------------------------------
package acr_pkg;

    // Field and port widths fixed by the stream and register formats
    localparam int IN_W      = 32;
    localparam int VPAGE_W   = 32;
    localparam int TARGET_W  = 11;
    localparam int HITCNT_W  = 32;
    localparam int RESULT_W  = 1 + 1 + VPAGE_W + TARGET_W + HITCNT_W;
    localparam int OUT_W     = ((RESULT_W + 7) / 8) * 8;
    localparam int CFG_W     = 11;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    localparam logic [CFG_W-1:0] CACHE_SIZE_RESET = 11'd1024;

    // Register index of cache_size within the register map
    localparam logic REG_CACHE_SIZE = 1'b0;

    // Directory list codes
    localparam logic [2:0] LST_FREE = 3'd0;
    localparam logic [2:0] LST_T1   = 3'd1;
    localparam logic [2:0] LST_T2   = 3'd2;
    localparam logic [2:0] LST_B1   = 3'd3;
    localparam logic [2:0] LST_B2   = 3'd4;

    // Index of each list in the head, tail and size arrays
    localparam logic [1:0] IX_T1 = 2'd0;
    localparam logic [1:0] IX_T2 = 2'd1;
    localparam logic [1:0] IX_B1 = 2'd2;
    localparam logic [1:0] IX_B2 = 2'd3;

    // One result, hit in the lowest bit
    typedef struct packed {
        logic [HITCNT_W-1:0] hit_total;
        logic [TARGET_W-1:0] target_t1;
        logic [VPAGE_W-1:0]  victim_page;
        logic                victim_valid;
        logic                hit;
    } acr_result_t;

    function automatic logic [1:0] list_index(input logic [2:0] code);
        return 2'(code - 3'd1);
    endfunction

endpackage

// ===== design/arc_cache_replacement.sv =====
// ---------------------------------------------------------------------------
// arc_cache_replacement
// Adaptive Replacement Cache policy engine with stream ports and APB setup.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries one page request per transfer (page number in tdata).
//   m_axis returns one result per request: hit, victim flag and page, the
//   new T1 target p and the running hit count.
//   The APB port holds cache_size at byte address 0; a write empties all
//   four lists and clears p, the hit count is kept. Write it only when idle.
// Timing:
//   A miss scans the N directory entries in use (up to 2*MAX_CAPACITY);
//   the lookup reads one entry per cycle from the page RAM. A ghost hit
//   whose step needs a ratio adds the divider, one quotient bit per
//   cycle. Each list move is an unlink (read links, then splice) plus a push.
// Reset and stall:
//   Reset empties the lists, clears p and the hit count, and sets
//   cache_size to 1024. No clearing pass is needed. A two-entry queue
//   keeps taking requests while m_axis is stalled; the finished result
//   waits in the output register and the engine holds in its last step.
// ---------------------------------------------------------------------------
module arc_cache_replacement
    import acr_pkg::*;
#(
    parameter int MAX_CAPACITY = 1024,
    parameter int PAGE_BITS    = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    // Request channel
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [IN_W-1:0]   s_axis_tdata,   // [31:0] page_number
    // Result channel
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_W-1:0]  m_axis_tdata,   // [0] hit, [1] victim_valid,
                                              // [33:2] victim_page,
                                              // [44:34] target_t1,
                                              // [76:45] hit_total, rest zero
    // Configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic [CFG_W-1:0]     cache_size_reg, cache_size_next;
    logic                 cfg_clear;
    logic                 q_valid, q_pop;
    logic [PAGE_BITS-1:0] q_page;
    acr_result_t          result;

    // Register write on the access phase
    assign pready    = 1'b1;
    assign cfg_clear = psel && penable && pwrite && pready
                       && (paddr[2] == REG_CACHE_SIZE);

    always_comb begin
        cache_size_next = cache_size_reg;
        if (cfg_clear) begin
            cache_size_next = CFG_W'(pwdata);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cache_size_reg <= CACHE_SIZE_RESET;
        end else begin
            cache_size_reg <= cache_size_next;
        end
    end

    assign prdata = (paddr[2] == REG_CACHE_SIZE) ? APB_DW'(cache_size_reg) : '0;

    acr_front #(.PAGE_BITS(PAGE_BITS)) u_front (
        .clk      (aclk),
        .rst_n    (aresetn),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .s_tdata  (s_axis_tdata),
        .q_valid  (q_valid),
        .q_page   (q_page),
        .q_pop    (q_pop)
    );

    acr_engine #(.MAX_CAPACITY(MAX_CAPACITY), .PAGE_BITS(PAGE_BITS)) u_engine (
        .clk        (aclk),
        .rst_n      (aresetn),
        .cache_size (cache_size_reg),
        .cfg_clear  (cfg_clear),
        .q_valid    (q_valid),
        .q_page     (q_page),
        .q_pop      (q_pop),
        .m_valid    (m_axis_tvalid),
        .m_ready    (m_axis_tready),
        .m_result   (result)
    );

    assign m_axis_tdata = OUT_W'(result);

endmodule

// ===== design/acr_ram.sv =====
// ---------------------------------------------------------------------------
// acr_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module acr_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    // Write, then register the read word
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/acr_div.sv =====
// ---------------------------------------------------------------------------
// acr_div
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module acr_div #(
    parameter int W = 14
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] num,
    input  logic [W-1:0] den,
    output logic         done,
    output logic [W-1:0] quo
);

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  den_reg, den_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W:0]    trial;

    // Shift in one numerator bit and try the subtraction
    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[W-1]};
        if (start) begin
            rem_next  = '0;
            quo_next  = num;
            den_next  = den;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_next = W'(trial - {1'b0, den_reg});
                quo_next = {quo_reg[W-2:0], 1'b1};
            end else begin
                rem_next = W'(trial);
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ===== design/acr_front.sv =====
// ---------------------------------------------------------------------------
// acr_front
// Request intake: masks the page number and queues requests for the engine.
// ---------------------------------------------------------------------------
module acr_front
    import acr_pkg::*;
#(
    parameter int PAGE_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_W-1:0]      s_tdata,
    output logic                 q_valid,
    output logic [PAGE_BITS-1:0] q_page,
    input  logic                 q_pop
);

    logic [PAGE_BITS-1:0] ent_reg [2];
    logic                 wr_ptr_reg, wr_ptr_next;
    logic                 rd_ptr_reg, rd_ptr_next;
    logic [1:0]           cnt_reg, cnt_next;
    logic                 push;

    assign s_tready = (cnt_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_page   = ent_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ q_pop;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
        if (push) begin
            ent_reg[wr_ptr_reg] <= PAGE_BITS'(s_tdata);
        end
    end

endmodule

// ===== design/acr_engine.sv =====
// ---------------------------------------------------------------------------
// acr_engine
// ARC policy engine: directory scan, list surgery in linked-list RAMs,
// target adaptation and the result register.
// ---------------------------------------------------------------------------
module acr_engine
    import acr_pkg::*;
#(
    parameter int MAX_CAPACITY = 1024,
    parameter int PAGE_BITS    = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [CFG_W-1:0]     cache_size,
    input  logic                 cfg_clear,
    input  logic                 q_valid,
    input  logic [PAGE_BITS-1:0] q_page,
    output logic                 q_pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output acr_result_t          m_result
);

    localparam int SLOTS = 2 * MAX_CAPACITY;
    localparam int IDXW  = $clog2(SLOTS);
    localparam int HW    = IDXW + 1;
    localparam int SW    = $clog2(SLOTS + 1);
    localparam int NW    = SW + 2;

    typedef enum logic [11:0] {
        ST_IDLE   = 12'b0000_0000_0001,
        ST_SCAN   = 12'b0000_0000_0010,
        ST_CLASS  = 12'b0000_0000_0100,
        ST_DIV    = 12'b0000_0000_1000,
        ST_GHOST  = 12'b0000_0001_0000,
        ST_DEL    = 12'b0000_0010_0000,
        ST_DEMOTE = 12'b0000_0100_0000,
        ST_PLACE  = 12'b0000_1000_0000,
        ST_ULRD   = 12'b0001_0000_0000,
        ST_ULWR   = 12'b0010_0000_0000,
        ST_PUSH   = 12'b0100_0000_0000,
        ST_DONE   = 12'b1000_0000_0000
    } state_t;

    state_t               state_reg, state_next;
    state_t               ret_reg, ret_next;
    logic [PAGE_BITS-1:0] pg_reg, pg_next;
    logic [HW-1:0]        scan_ptr_reg, scan_ptr_next;
    logic                 cmp_v_reg, cmp_v_next;
    logic [IDXW-1:0]      cmp_idx_reg, cmp_idx_next;
    logic                 found_reg, found_next;
    logic [IDXW-1:0]      s_reg, s_next;
    logic [2:0]           lst_reg, lst_next;
    logic [HW-1:0]        hwm_reg, hwm_next;
    logic [SW-1:0]        size_reg [4];
    logic [SW-1:0]        size_next [4];
    logic [IDXW-1:0]      head_reg [4];
    logic [IDXW-1:0]      head_next [4];
    logic [IDXW-1:0]      tail_reg [4];
    logic [IDXW-1:0]      tail_next [4];
    logic [SW-1:0]        p_reg, p_next;
    logic [HITCNT_W-1:0]  hc_reg, hc_next;
    logic                 hit_reg, hit_next;
    logic                 vv_reg, vv_next;
    logic [PAGE_BITS-1:0] vp_reg, vp_next;
    logic                 xb2_reg, xb2_next;
    logic [NW-1:0]        d_reg, d_next;
    logic                 del_en_reg, del_en_next;
    logic [1:0]           del_l_reg, del_l_next;
    logic                 del_cap_reg, del_cap_next;
    logic                 dem_en_reg, dem_en_next;
    logic [IDXW-1:0]      ul_x_reg, ul_x_next;
    logic [1:0]           ul_l_reg, ul_l_next;
    logic                 cap_reg, cap_next;
    logic                 push_pend_reg, push_pend_next;
    logic [IDXW-1:0]      ps_x_reg, ps_x_next;
    logic [2:0]           ps_l_reg, ps_l_next;
    logic                 free_v_reg, free_v_next;
    logic [IDXW-1:0]      free_x_reg, free_x_next;
    logic                 out_v_reg, out_v_next;
    acr_result_t          out_reg, out_next;

    // RAM ports
    logic [IDXW-1:0]      dir_raddr, link_raddr;
    logic                 page_we, list_we, prev_we, next_we;
    logic [IDXW-1:0]      page_waddr, list_waddr, prev_waddr, next_waddr;
    logic [PAGE_BITS-1:0] page_wdata, page_rd;
    logic [2:0]           list_wdata, list_rd;
    logic [IDXW-1:0]      prev_wdata, next_wdata, prev_rd, next_rd;

    // Divider port
    logic                 div_start, div_done;
    logic [NW-1:0]        div_num, div_den, div_quo;

    // Working values
    logic [SW-1:0]        c_eff;
    logic [SW-1:0]        own, other;
    logic [SW:0]          sum1;
    logic [SW+1:0]        total;
    logic [NW:0]          np;
    logic                 from_t1;
    logic [1:0]           src;
    logic [1:0]           li;
    logic [IDXW-1:0]      alloc;

    acr_ram #(.DATA_W(PAGE_BITS), .DEPTH(SLOTS)) u_page_ram (
        .clk(clk), .we(page_we), .waddr(page_waddr), .wdata(page_wdata),
        .raddr(dir_raddr), .rdata(page_rd)
    );
    acr_ram #(.DATA_W(3), .DEPTH(SLOTS)) u_list_ram (
        .clk(clk), .we(list_we), .waddr(list_waddr), .wdata(list_wdata),
        .raddr(dir_raddr), .rdata(list_rd)
    );
    acr_ram #(.DATA_W(IDXW), .DEPTH(SLOTS)) u_prev_ram (
        .clk(clk), .we(prev_we), .waddr(prev_waddr), .wdata(prev_wdata),
        .raddr(link_raddr), .rdata(prev_rd)
    );
    acr_ram #(.DATA_W(IDXW), .DEPTH(SLOTS)) u_next_ram (
        .clk(clk), .we(next_we), .waddr(next_waddr), .wdata(next_wdata),
        .raddr(link_raddr), .rdata(next_rd)
    );

    acr_div #(.W(NW)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num),
        .den(div_den), .done(div_done), .quo(div_quo)
    );

    // Clamp the capacity to 1..MAX_CAPACITY
    always_comb begin
        if (cache_size == '0) begin
            c_eff = SW'(1);
        end else if (32'(cache_size) > 32'(MAX_CAPACITY)) begin
            c_eff = SW'(MAX_CAPACITY);
        end else begin
            c_eff = SW'(cache_size);
        end
    end

    assign dir_raddr  = (state_reg == ST_SCAN) ? scan_ptr_reg[IDXW-1:0] : ul_x_reg;
    assign link_raddr = ul_x_reg;

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        pg_next        = pg_reg;
        scan_ptr_next  = scan_ptr_reg;
        cmp_v_next     = cmp_v_reg;
        cmp_idx_next   = cmp_idx_reg;
        found_next     = found_reg;
        s_next         = s_reg;
        lst_next       = lst_reg;
        hwm_next       = hwm_reg;
        size_next      = size_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        p_next         = p_reg;
        hc_next        = hc_reg;
        hit_next       = hit_reg;
        vv_next        = vv_reg;
        vp_next        = vp_reg;
        xb2_next       = xb2_reg;
        d_next         = d_reg;
        del_en_next    = del_en_reg;
        del_l_next     = del_l_reg;
        del_cap_next   = del_cap_reg;
        dem_en_next    = dem_en_reg;
        ul_x_next      = ul_x_reg;
        ul_l_next      = ul_l_reg;
        cap_next       = cap_reg;
        push_pend_next = push_pend_reg;
        ps_x_next      = ps_x_reg;
        ps_l_next      = ps_l_reg;
        free_v_next    = free_v_reg;
        free_x_next    = free_x_reg;
        out_next       = out_reg;
        out_v_next     = out_v_reg && !m_ready;
        q_pop          = 1'b0;
        page_we        = 1'b0;
        page_waddr     = free_x_reg;
        page_wdata     = pg_reg;
        list_we        = 1'b0;
        list_waddr     = ps_x_reg;
        list_wdata     = ps_l_reg;
        prev_we        = 1'b0;
        prev_waddr     = ps_x_reg;
        prev_wdata     = ps_x_reg;
        next_we        = 1'b0;
        next_waddr     = ps_x_reg;
        next_wdata     = ps_x_reg;
        div_start      = 1'b0;
        own            = (lst_reg == LST_B2) ? size_reg[IX_B2] : size_reg[IX_B1];
        other          = (lst_reg == LST_B2) ? size_reg[IX_B1] : size_reg[IX_B2];
        div_num        = NW'({other, 1'b0}) + NW'(own);
        div_den        = NW'({own, 1'b0});
        sum1           = (SW+1)'(size_reg[IX_T1]) + (SW+1)'(size_reg[IX_B1]);
        total          = (SW+2)'(size_reg[IX_T1]) + (SW+2)'(size_reg[IX_T2])
                       + (SW+2)'(size_reg[IX_B1]) + (SW+2)'(size_reg[IX_B2]);
        np             = (NW+1)'(p_reg) + (NW+1)'(d_reg);
        from_t1        = 1'b0;
        src            = IX_T2;
        li             = ul_l_reg;
        alloc          = free_x_reg;

        unique case (state_reg)
            ST_IDLE: begin
                // Take the next queued request
                if (q_valid) begin
                    q_pop         = 1'b1;
                    pg_next       = q_page;
                    scan_ptr_next = '0;
                    cmp_v_next    = 1'b0;
                    found_next    = 1'b0;
                    hit_next      = 1'b0;
                    vv_next       = 1'b0;
                    vp_next       = '0;
                    xb2_next      = 1'b0;
                    del_en_next   = 1'b0;
                    dem_en_next   = 1'b0;
                    free_v_next   = 1'b0;
                    d_next        = NW'(1);
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // Read one slot a cycle, compare the word read last cycle
                if (cmp_v_reg && list_rd != LST_FREE && page_rd == pg_reg) begin
                    found_next = 1'b1;
                    s_next     = cmp_idx_reg;
                    lst_next   = list_rd;
                    state_next = ST_CLASS;
                end else if (scan_ptr_reg >= hwm_reg && !cmp_v_reg) begin
                    state_next = ST_CLASS;
                end else begin
                    cmp_v_next   = (scan_ptr_reg < hwm_reg);
                    cmp_idx_next = scan_ptr_reg[IDXW-1:0];
                    if (scan_ptr_reg < hwm_reg) begin
                        scan_ptr_next = scan_ptr_reg + 1'b1;
                    end
                end
            end
            ST_CLASS: begin
                if (found_reg) begin
                    case (lst_reg) inside
                        LST_T1, LST_T2: begin
                            hit_next   = 1'b1;
                            hc_next    = hc_reg + 1'b1;
                            state_next = ST_PLACE;
                        end
                        LST_B1, LST_B2: begin
                            xb2_next = (lst_reg == LST_B2);
                            if (own == '0 || own >= other) begin
                                d_next     = NW'(1);
                                state_next = ST_GHOST;
                            end else begin
                                div_start  = 1'b1;
                                state_next = ST_DIV;
                            end
                        end
                        default: begin
                            state_next = ST_PLACE;
                        end
                    endcase
                end else begin
                    // Miss: pick what leaves the directory before the insert
                    if (sum1 >= (SW+1)'(c_eff)) begin
                        if (size_reg[IX_T1] < c_eff) begin
                            del_en_next  = (size_reg[IX_B1] != '0);
                            del_l_next   = IX_B1;
                            del_cap_next = 1'b0;
                            dem_en_next  = 1'b1;
                        end else begin
                            del_en_next  = 1'b1;
                            del_l_next   = IX_T1;
                            del_cap_next = 1'b1;
                            dem_en_next  = 1'b0;
                        end
                    end else if (total >= (SW+2)'(c_eff)) begin
                        del_en_next  = (total >= (SW+2)'({c_eff, 1'b0}))
                                       && (size_reg[IX_B2] != '0);
                        del_l_next   = IX_B2;
                        del_cap_next = 1'b0;
                        dem_en_next  = 1'b1;
                    end
                    state_next = ST_DEL;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    d_next     = div_quo;
                    state_next = ST_GHOST;
                end
            end
            ST_GHOST: begin
                // Move the target toward the list that got the ghost hit
                if (!xb2_reg) begin
                    p_next = (np < (NW+1)'(c_eff)) ? SW'(np) : c_eff;
                end else begin
                    p_next = (NW'(p_reg) > d_reg) ? SW'(NW'(p_reg) - d_reg) : '0;
                end
                dem_en_next = 1'b1;
                state_next  = ST_DEMOTE;
            end
            ST_DEL: begin
                // Drop the LRU entry of the chosen list, keep its slot
                if (del_en_reg) begin
                    ul_x_next      = tail_reg[del_l_reg];
                    ul_l_next      = del_l_reg;
                    cap_next       = del_cap_reg;
                    vv_next        = vv_reg | del_cap_reg;
                    free_v_next    = 1'b1;
                    free_x_next    = tail_reg[del_l_reg];
                    push_pend_next = 1'b0;
                    ret_next       = ST_DEMOTE;
                    state_next     = ST_ULRD;
                end else begin
                    state_next = ST_DEMOTE;
                end
            end
            ST_DEMOTE: begin
                // Demote the LRU resident page to its ghost list
                from_t1 = (size_reg[IX_T1] != '0)
                          && ((size_reg[IX_T1] > p_reg)
                              || (xb2_reg && size_reg[IX_T1] == p_reg));
                if (!from_t1 && size_reg[IX_T2] == '0) begin
                    from_t1 = 1'b1;
                end
                if (from_t1 && size_reg[IX_T1] == '0) begin
                    from_t1 = 1'b0;
                end
                src = from_t1 ? IX_T1 : IX_T2;
                if (dem_en_reg && size_reg[src] != '0) begin
                    ul_x_next      = tail_reg[src];
                    ul_l_next      = src;
                    cap_next       = 1'b1;
                    vv_next        = 1'b1;
                    push_pend_next = 1'b1;
                    ps_x_next      = tail_reg[src];
                    ps_l_next      = from_t1 ? LST_B1 : LST_B2;
                    ret_next       = ST_PLACE;
                    state_next     = ST_ULRD;
                end else begin
                    state_next = ST_PLACE;
                end
            end
            ST_PLACE: begin
                if (found_reg) begin
                    // Hit or ghost hit: move the page to the front of T2
                    ul_x_next      = s_reg;
                    ul_l_next      = list_index(lst_reg);
                    cap_next       = 1'b0;
                    push_pend_next = 1'b1;
                    ps_x_next      = s_reg;
                    ps_l_next      = LST_T2;
                    ret_next       = ST_DONE;
                    state_next     = ST_ULRD;
                end else begin
                    // Miss: reuse the freed slot or take a fresh one
                    if (free_v_reg) begin
                        alloc = free_x_reg;
                    end else begin
                        alloc = hwm_reg[IDXW-1:0];
                    end
                    if (free_v_reg || hwm_reg < HW'(SLOTS)) begin
                        if (!free_v_reg) begin
                            hwm_next = hwm_reg + 1'b1;
                        end
                        page_we    = 1'b1;
                        page_waddr = alloc;
                        ps_x_next  = alloc;
                        ps_l_next  = LST_T1;
                        ret_next   = ST_DONE;
                        state_next = ST_PUSH;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_ULRD: begin
                state_next = ST_ULWR;
            end
            ST_ULWR: begin
                // Splice the node out using the links read last cycle
                if (ul_x_reg == head_reg[li]) begin
                    head_next[li] = next_rd;
                end else begin
                    next_we    = 1'b1;
                    next_waddr = prev_rd;
                    next_wdata = next_rd;
                end
                if (ul_x_reg == tail_reg[li]) begin
                    tail_next[li] = prev_rd;
                end else begin
                    prev_we    = 1'b1;
                    prev_waddr = next_rd;
                    prev_wdata = prev_rd;
                end
                if (cap_reg) begin
                    vp_next = page_rd;
                end
                size_next[li] = size_reg[li] - 1'b1;
                state_next    = push_pend_reg ? ST_PUSH : ret_reg;
            end
            ST_PUSH: begin
                // Link the node in as the most recent of its list
                li         = list_index(ps_l_reg);
                next_we    = 1'b1;
                next_waddr = ps_x_reg;
                next_wdata = head_reg[li];
                if (size_reg[li] != '0) begin
                    prev_we    = 1'b1;
                    prev_waddr = head_reg[li];
                    prev_wdata = ps_x_reg;
                end else begin
                    tail_next[li] = ps_x_reg;
                end
                head_next[li]  = ps_x_reg;
                size_next[li]  = size_reg[li] + 1'b1;
                list_we        = 1'b1;
                push_pend_next = 1'b0;
                state_next     = ret_reg;
            end
            ST_DONE: begin
                // Load the result register once it is free
                if (!out_v_reg || m_ready) begin
                    out_next.hit          = hit_reg;
                    out_next.victim_valid = vv_reg;
                    out_next.victim_page  = vv_reg ? VPAGE_W'(vp_reg) : '0;
                    out_next.target_t1    = TARGET_W'(p_reg);
                    out_next.hit_total    = hc_reg;
                    out_v_next            = 1'b1;
                    state_next            = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Capacity write empties all lists and clears the target
        if (cfg_clear) begin
            hwm_next = '0;
            p_next   = '0;
            for (int i = 0; i < 4; i++) begin
                size_next[i] = '0;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
            hwm_reg   <= '0;
            p_reg     <= '0;
            hc_reg    <= '0;
            out_v_reg <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                size_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            hwm_reg   <= hwm_next;
            p_reg     <= p_next;
            hc_reg    <= hc_next;
            out_v_reg <= out_v_next;
            size_reg  <= size_next;
        end
        pg_reg        <= pg_next;
        scan_ptr_reg  <= scan_ptr_next;
        cmp_v_reg     <= cmp_v_next;
        cmp_idx_reg   <= cmp_idx_next;
        found_reg     <= found_next;
        s_reg         <= s_next;
        lst_reg       <= lst_next;
        head_reg      <= head_next;
        tail_reg      <= tail_next;
        hit_reg       <= hit_next;
        vv_reg        <= vv_next;
        vp_reg        <= vp_next;
        xb2_reg       <= xb2_next;
        d_reg         <= d_next;
        del_en_reg    <= del_en_next;
        del_l_reg     <= del_l_next;
        del_cap_reg   <= del_cap_next;
        dem_en_reg    <= dem_en_next;
        ul_x_reg      <= ul_x_next;
        ul_l_reg      <= ul_l_next;
        cap_reg       <= cap_next;
        push_pend_reg <= push_pend_next;
        ps_x_reg      <= ps_x_next;
        ps_l_reg      <= ps_l_next;
        free_v_reg    <= free_v_next;
        free_x_reg    <= free_x_next;
        out_reg       <= out_next;
    end

    assign m_valid  = out_v_reg;
    assign m_result = out_reg;

endmodule

// ===== design/acr_checker.sv =====
// ---------------------------------------------------------------------------
// acr_checker
// Port-level checks on the ARC replacement block, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module acr_checker
    import acr_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata,
    input logic             pready
);

    // Reset drops any pending result
    `ACR_ASSERT_ANY(a_reset_clears_out, aclk, !aresetn |=> !m_axis_tvalid, "result valid after reset")

    // A stalled result stays put
    `ACR_ASSERT_RST(a_hold_on_stall, aclk, aresetn, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

    // A hit never demotes a resident page
    `ACR_ASSERT_RST(a_no_victim_on_hit, aclk, aresetn, m_axis_tvalid && m_axis_tdata[0] |-> !m_axis_tdata[1], "victim reported on a hit")

    // Victim page reads zero when no victim
    `ACR_ASSERT_RST(a_victim_zero, aclk, aresetn, m_axis_tvalid && !m_axis_tdata[1] |-> m_axis_tdata[33:2] == 32'd0, "victim page without victim")

    // Config port never waits
    `ACR_ASSERT_ANY(a_pready_high, aclk, pready, "pready low")

endmodule

bind arc_cache_replacement acr_checker u_acr_checker (.*);

// ===== tb/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ARC replacement engine: a queue-fed stream
// driver, a result monitor checked against a list-based ARC predictor, and
// APB writes of cache_size between phases of directed and random requests.
// ---------------------------------------------------------------------------
module tb_top;
    import acr_pkg::*;

    typedef logic [31:0] page_list_t[$];

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata = '0;    // [31:0] page_number
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_W-1:0]  m_axis_tdata;         // [0] hit, [1] victim_valid, [33:2] victim_page,
                                             // [44:34] target_t1, [76:45] hit_total
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    arc_cache_replacement DUT (.*);

    always #4 aclk = ~aclk;

    // Predictor state: front of each list is the most recent page
    page_list_t  res_t1, res_t2, ghost_b1, ghost_b2;
    int          target_p;
    logic [31:0] hit_tally;
    logic [10:0] cfg_size;

    logic [31:0] pending_pages[$];
    acr_result_t expected_results[$];
    int          mismatches = 0;
    int          idle_mode = 0;
    logic        req_fire = 1'b0;
    int          hold_left = 0;
    int          hold_arm = 0;
    int          hold_seen = 0;

    function automatic int find_page(input page_list_t q, input logic [31:0] page);
        foreach (q[i]) if (q[i] == page) return i;
        return -1;
    endfunction

    function automatic int ghost_step(input int own, input int other);
        if (own == 0 || own >= other) return 1;
        return (2 * other + own) / (2 * own);
    endfunction

    // ARC REPLACE: demote the LRU of T1 to B1 or of T2 to B2
    task automatic demote_resident(input bit in_b2, inout bit vv, inout logic [31:0] vp);
        int  n1;
        bit  from_t1;
        n1 = res_t1.size();
        from_t1 = n1 > 0 && (n1 > target_p || (in_b2 && n1 == target_p));
        if (!from_t1 && res_t2.size() == 0) from_t1 = 1;
        if (from_t1 && n1 == 0) from_t1 = 0;
        if (from_t1) begin
            vp = res_t1.pop_back();
            ghost_b1.push_front(vp);
            vv = 1;
        end else if (res_t2.size() > 0) begin
            vp = res_t2.pop_back();
            ghost_b2.push_front(vp);
            vv = 1;
        end
    endtask

    task automatic predict_request(input logic [31:0] page);
        acr_result_t r;
        int          c, i, d, total, n1, nb1;
        bit          vv;
        logic [31:0] vp;
        bit          is_hit;
        c = (cfg_size == 0) ? 1 : (cfg_size > 1024 ? 1024 : int'(cfg_size));
        vv = 0;
        vp = '0;
        is_hit = 0;
        if ((i = find_page(res_t1, page)) >= 0) begin
            res_t1.delete(i);
            res_t2.push_front(page);
            is_hit = 1;
        end else if ((i = find_page(res_t2, page)) >= 0) begin
            res_t2.delete(i);
            res_t2.push_front(page);
            is_hit = 1;
        end else if (find_page(ghost_b1, page) >= 0) begin
            d = ghost_step(ghost_b1.size(), ghost_b2.size());
            target_p = (target_p + d < c) ? target_p + d : c;
            demote_resident(0, vv, vp);
            ghost_b1.delete(find_page(ghost_b1, page));
            res_t2.push_front(page);
        end else if (find_page(ghost_b2, page) >= 0) begin
            d = ghost_step(ghost_b2.size(), ghost_b1.size());
            target_p = (target_p > d) ? target_p - d : 0;
            demote_resident(1, vv, vp);
            ghost_b2.delete(find_page(ghost_b2, page));
            res_t2.push_front(page);
        end else begin
            n1 = res_t1.size();
            nb1 = ghost_b1.size();
            total = n1 + res_t2.size() + nb1 + ghost_b2.size();
            if (n1 + nb1 >= c) begin
                if (n1 < c) begin
                    if (nb1 > 0) void'(ghost_b1.pop_back());
                    demote_resident(0, vv, vp);
                end else begin
                    vp = res_t1.pop_back();
                    vv = 1;
                end
            end else if (total >= c) begin
                if (total >= 2 * c && ghost_b2.size() > 0) void'(ghost_b2.pop_back());
                demote_resident(0, vv, vp);
            end
            res_t1.push_front(page);
        end
        if (is_hit) hit_tally = hit_tally + 1;
        r.hit = is_hit;
        r.victim_valid = vv;
        r.victim_page = vv ? vp : '0;
        r.target_t1 = target_p[10:0];
        r.hit_total = hit_tally;
        expected_results.push_back(r);
    endtask

    task automatic clear_predictor();
        res_t1.delete();
        res_t2.delete();
        ghost_b1.delete();
        ghost_b2.delete();
        target_p = 0;
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // Driver: offer the next request at the falling edge
    always @(negedge aclk) begin
        if (aresetn && (!s_axis_tvalid || req_fire)) begin
            if (pending_pages.size() > 0 &&
                !((idle_mode == 1 && $urandom_range(99) < 62) ||
                  (idle_mode == 3 && $urandom_range(99) < 34))) begin
                s_axis_tdata <= pending_pages.pop_front();
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls plus a long hold-off on request
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_arm != hold_seen) begin
            hold_seen <= hold_arm;
            hold_left <= 600;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= !((idle_mode == 2 && $urandom_range(99) < 62) ||
                               (idle_mode == 3 && $urandom_range(99) < 34));
        end
    end

    // Monitor: predict on accepted requests, check accepted results
    always @(posedge aclk) begin
        acr_result_t got, want;
        req_fire <= s_axis_tvalid && s_axis_tready;
        if (aresetn && s_axis_tvalid && s_axis_tready) predict_request(s_axis_tdata);
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = acr_result_t'(m_axis_tdata[RESULT_W-1:0]);
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", got.victim_page, '0);
            end else begin
                want = expected_results.pop_front();
                if (got.hit !== want.hit)
                    report_mismatch("hit", 32'(got.hit), 32'(want.hit));
                if (got.victim_valid !== want.victim_valid)
                    report_mismatch("victim_valid", 32'(got.victim_valid),
                                    32'(want.victim_valid));
                if (got.victim_page !== want.victim_page)
                    report_mismatch("victim_page", got.victim_page, want.victim_page);
                if (got.target_t1 !== want.target_t1)
                    report_mismatch("target_t1", 32'(got.target_t1), 32'(want.target_t1));
                if (got.hit_total !== want.hit_total)
                    report_mismatch("hit_total", got.hit_total, want.hit_total);
            end
        end
    end

    task automatic wait_drained();
        while (pending_pages.size() > 0 || expected_results.size() > 0 || s_axis_tvalid)
            @(posedge aclk);
    endtask

    // Write cache_size over APB: setup then access
    task automatic write_cache_size(input logic [31:0] value);
        @(negedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {REG_CACHE_SIZE, 2'b00};
        pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        cfg_size = value[10:0];
        clear_predictor();
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Random phase: requests drawn mostly from a small pool of pages, or all random when noise_only is set
    task automatic random_phase(input logic [31:0] size, input int count, input int pool_n,
                                input int mode, input bit noise_only);
        logic [31:0] pool[];
        wait_drained();
        idle_mode = mode;
        write_cache_size(size);
        pool = new[pool_n];
        foreach (pool[i]) pool[i] = $urandom();
        for (int k = 0; k < count; k++) begin
            if (noise_only || $urandom_range(9) == 0)
                pending_pages.push_back($urandom());
            else if ($urandom_range(1))
                pending_pages.push_back(pool[$urandom_range(pool_n / 3)]);
            else
                pending_pages.push_back(pool[$urandom_range(pool_n - 1)]);
        end
    endtask

    initial begin
        logic [31:0] seq_c2[$];
        cfg_size = CACHE_SIZE_RESET;
        clear_predictor();
        hit_tally = '0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: field extremes at the reset capacity
        pending_pages = '{32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'hAAAA_AAAA,
                          32'h5555_5555, 32'hAAAA_AAAA};
        // Directed: capacity two, drive T1 overflow
        wait_drained();
        write_cache_size(2);
        seq_c2 = '{1, 2, 3, 1, 4, 4, 5, 6, 4, 2, 7, 5, 8, 6, 1};
        pending_pages = seq_c2;
        // Directed: capacity zero acts as one
        wait_drained();
        write_cache_size(0);
        pending_pages = '{9, 9, 10, 9};

        random_phase(1, 60, 4, 0, 0);
        random_phase(4, 80, 12, 1, 0);
        random_phase(8, 90, 24, 2, 0);
        random_phase(3, 70, 9, 3, 0);
        // Long receiver hold-off so the input side fills and stalls
        wait_drained();
        hold_arm = hold_arm + 1;
        random_phase(16, 90, 48, 0, 0);
        random_phase(5, 80, 15, 3, 0);
        random_phase(32, 90, 96, 1, 0);
        random_phase(2, 60, 6, 2, 0);
        random_phase(6, 40, 12, 0, 1);
        random_phase(2047, 30, 20, 3, 0);
        random_phase(1024, 30, 20, 2, 0);
        random_phase(7, 80, 21, 3, 0);

        wait_drained();
        repeat (100) @(posedge aclk);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #(8 * 3_000_000);
        $display("TB_ERROR");
        $finish;
    end

endmodule
